@@ hdl/ssfm_pkg.sv @@
// shared types and constants for the first-match substring search block
// no dependencies; imported by every module and interface of the block
package ssfm_pkg;

	localparam int PATTERN_MAX = 64;
	localparam int TEXT_MAX    = 65536;
	localparam int BYTE_W      = 8;
	localparam int OFFSET_W    = 16;
	localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
	localparam int CNT_W       = $clog2(TEXT_MAX + 1);

	typedef enum logic {
		OP_PATTERN = 1'b0,
		OP_TEXT    = 1'b1
	} op_t;

	typedef logic [BYTE_W-1:0] data_t;
	typedef data_t [PATTERN_MAX-1:0] bytes_t;
	typedef logic [PATTERN_MAX-1:0] mask_t;
	typedef logic [LEN_W-1:0] len_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [OFFSET_W-1:0] offset_t;

	// pattern loader control
	typedef struct packed {
		logic  load;
		logic  last;
		data_t data;
	} pat_ctl_t;

	// pattern loader status
	typedef struct packed {
		len_t len;
		logic complete;
	} pat_stat_t;

	// text window control
	typedef struct packed {
		logic  shift;
		logic  clear;
		data_t data;
	} win_ctl_t;

endpackage

@@ hdl/ssfm_if.sv @@
// valid/ready channel interfaces for the search block: input items and results
// depends on ssfm_pkg
interface ssfm_in_if import ssfm_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  operation;
	data_t data_byte;
	logic  is_last;

	modport source (output valid, output operation, output data_byte, output is_last,
		input ready);
	modport sink (input valid, input operation, input data_byte, input is_last,
		output ready);
endinterface

interface ssfm_out_if import ssfm_pkg::*; ();
	logic    valid;
	logic    ready;
	logic    found;
	offset_t match_offset;

	modport source (output valid, output found, output match_offset, input ready);
	modport sink (input valid, input found, input match_offset, output ready);
endinterface

@@ hdl/ssfm_pattern.sv @@
// pattern store: shift line of loaded bytes, newest first, with a length mask
// depends on ssfm_pkg
module ssfm_pattern import ssfm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  pat_ctl_t  ctl,
	output bytes_t    pat,
	output mask_t     mask,
	output pat_stat_t stat
);

	bytes_t pat_q;
	mask_t  mask_q;
	len_t   len_q;
	logic   complete_q;

	mask_t mask_base;
	len_t  len_base;
	logic  room;

	// a byte after a closed pattern starts a new one
	always_comb begin
		mask_base = complete_q ? '0 : mask_q;
		len_base  = complete_q ? '0 : len_q;
		room      = len_base < LEN_W'(PATTERN_MAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q     <= '0;
			len_q      <= '0;
			complete_q <= 1'b0;
		end else if (ctl.load) begin
			complete_q <= ctl.last;
			if (room) begin
				mask_q <= {mask_base[PATTERN_MAX-2:0], 1'b1};
				len_q  <= len_base + len_t'(1);
			end else begin
				mask_q <= mask_base;
				len_q  <= len_base;
			end
		end
	end

	// payload only, no reset; written while there is room, read through the mask
	always_ff @(posedge clk) begin
		if (ctl.load && room) begin
			pat_q <= {pat_q[PATTERN_MAX-2:0], ctl.data};
		end
	end

	assign pat           = pat_q;
	assign mask          = mask_q;
	assign stat.len      = len_q;
	assign stat.complete = complete_q;

endmodule

@@ hdl/ssfm_window.sv @@
// text window shift line and parallel compare against the pattern
// depends on ssfm_pkg
module ssfm_window import ssfm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  win_ctl_t ctl,
	input  bytes_t   pat,
	input  mask_t    mask,
	output logic     hit
);

	bytes_t win_q;
	bytes_t win_shift;
	mask_t  ok;

	// compare is on the window with the incoming byte already shifted in
	always_comb begin
		win_shift = {win_q[PATTERN_MAX-2:0], ctl.data};
		for (int k = 0; k < PATTERN_MAX; k++) begin
			ok[k] = !mask[k] || (win_shift[k] == pat[k]);
		end
		hit = mask[0] && (&ok);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (ctl.clear) begin
			win_q <= '0;
		end else if (ctl.shift) begin
			win_q <= win_shift;
		end
	end

endmodule

@@ hdl/substring_search_first_match.sv @@
// top level of the first-match substring search block
// depends on ssfm_pkg, ssfm_if, ssfm_pattern and ssfm_window
//
// usage: input transactions on item carry operation, data_byte and is_last.
// operation = pattern loads one pattern byte; is_last closes the pattern, and
// a pattern byte after a closed pattern starts a new one. every pattern byte
// also clears the text search. operation = text streams one text byte of the
// buffer; the byte flagged is_last closes the buffer and yields exactly one
// result transaction on result: found and the start offset of the first full
// match (0 when not found). the pattern is kept across buffers.
// pipeline: one input register stage and one result register; a closing
// text byte passes the input stage, then sets the result register, which
// drives result.valid. throughput: one item per cycle unless the input
// stage holds (see stall); the whole window (up to PATTERN_MAX bytes) is
// compared against the pattern combinationally between the two registers.
// stall: the result register is the only buffer on the output side; while a
// result waits, items keep flowing until a second closing text byte reaches
// the input stage, which then holds and drops item.ready.
// reset: arst_n clears the pattern length, the text window and the search
// state; no pattern matches until one is loaded and closed.
module substring_search_first_match import ssfm_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	ssfm_in_if.sink    item,
	ssfm_out_if.source result
);

	// input stage
	logic  valid_s1;
	logic  op_s1;
	data_t data_s1;
	logic  last_s1;

	// search state
	cnt_t    count_q;
	logic    seen_q;
	offset_t offset_q;

	// result register
	logic    out_valid_q;
	logic    found_q;
	offset_t match_offset_q;

	pat_ctl_t  pat_ctl;
	win_ctl_t  win_ctl;
	bytes_t    pat;
	mask_t     mask;
	pat_stat_t pat_stat;
	logic      win_hit;

	logic    out_free;
	logic    advance;
	logic    is_text;
	logic    in_range;
	cnt_t    count_next;
	logic    new_match;
	logic    seen_next;
	offset_t offset_next;
	logic    emit;
	logic [CNT_W-1:0] diff;

	assign out_free   = !out_valid_q || result.ready;
	assign is_text    = (op_s1 == OP_TEXT);
	// a closing text byte waits until the result register can take it
	assign advance    = valid_s1 && (!(is_text && last_s1) || out_free);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			op_s1   <= item.operation;
			data_s1 <= item.data_byte;
			last_s1 <= item.is_last;
		end
	end

	// search datapath
	always_comb begin
		in_range   = count_q < CNT_W'(TEXT_MAX);
		count_next = count_q + cnt_t'(1);
		diff       = count_next - CNT_W'(pat_stat.len);
		new_match  = in_range && pat_stat.complete && !seen_q
			&& (count_next >= CNT_W'(pat_stat.len)) && win_hit;
		seen_next   = seen_q || new_match;
		offset_next = new_match ? diff[OFFSET_W-1:0] : offset_q;
		emit        = advance && is_text && last_s1;

		pat_ctl.load = advance && !is_text;
		pat_ctl.last = last_s1;
		pat_ctl.data = data_s1;

		win_ctl.shift = advance && is_text && in_range;
		win_ctl.clear = (advance && !is_text) || emit;
		win_ctl.data  = data_s1;
	end

	ssfm_pattern u_pattern (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (pat_ctl),
		.pat    (pat),
		.mask   (mask),
		.stat   (pat_stat)
	);

	ssfm_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (win_ctl),
		.pat    (pat),
		.mask   (mask),
		.hit    (win_hit)
	);

	// count, first-match flag and offset; cleared by pattern bytes and buffer end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			seen_q   <= 1'b0;
			offset_q <= '0;
		end else if (win_ctl.clear) begin
			count_q  <= '0;
			seen_q   <= 1'b0;
			offset_q <= '0;
		end else if (win_ctl.shift) begin
			count_q  <= count_next;
			seen_q   <= seen_next;
			offset_q <= offset_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// text bytes past the buffer limit do not update the match state
	always_ff @(posedge clk) begin
		if (emit) begin
			found_q        <= in_range ? seen_next : seen_q;
			match_offset_q <= in_range ? (seen_next ? offset_next : '0)
				: (seen_q ? offset_q : '0);
		end
	end

	assign result.valid        = out_valid_q;
	assign result.found        = found_q;
	assign result.match_offset = match_offset_q;

endmodule

@@ verif/testbench.sv @@
// self-checking bench for substring_search_first_match: random and directed pattern/text traffic
// predicts each buffer's first-match result and compares it with the result channel
// depends on ssfm_pkg, ssfm_if and the search block itself
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import ssfm_pkg::*;

	localparam int RANDOM_ITEMS = 1250;
	localparam int IDLE_LIMIT   = 1000;   // cycles without any transaction before giving up
	localparam int DRAIN_CYCLES = 8;      // result register plus input stage, with margin

	// one input transaction as the sender sees it
	typedef struct {
		op_t   op;
		data_t data;
		logic  last;
	} search_item_t;

	// one result transaction: the outcome of one closed text buffer
	typedef struct {
		logic    found;
		offset_t offset;
	} match_result_t;

	logic clk = 1'b0;
	logic arst_n;

	ssfm_in_if  item_ch ();
	ssfm_out_if result_ch ();

	substring_search_first_match i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// stimulus still to be sent, and first-match outcomes still to arrive
	search_item_t  byte_queue [$];
	match_result_t match_queue [$];

	int items_total    = 0;
	int items_taken    = 0;
	int results_seen   = 0;
	int hits_seen      = 0;
	int mismatch_count = 0;
	int idle_cycles    = 0;

	// ------------------------------------------------------------------
	// predictor state: pattern memory, text window (entry 0 is newest)
	// and the running search of the current buffer
	// ------------------------------------------------------------------
	data_t pat_mem [PATTERN_MAX];
	int    pat_len    = 0;
	logic  pat_closed = 1'b0;
	data_t win [PATTERN_MAX];
	int    txt_cnt    = 0;
	logic  hit        = 1'b0;
	int    hit_off    = 0;

	initial foreach (win[k]) win[k] = '0;

	function automatic void clear_search_state();
		foreach (win[k]) win[k] = '0;
		txt_cnt = 0;
		hit     = 1'b0;
		hit_off = 0;
	endfunction

	// advance the predicted search by one accepted transaction
	task automatic predict_search(input search_item_t it);
		match_result_t res;
		logic          same;
		if (it.op == OP_PATTERN) begin
			// a pattern byte after a closed pattern starts a fresh one
			if (pat_closed) begin
				pat_closed = 1'b0;
				pat_len    = 0;
			end
			// bytes past the pattern memory are dropped, length saturates
			if (pat_len < PATTERN_MAX) begin
				pat_mem[pat_len] = it.data;
				pat_len++;
			end
			if (it.last)
				pat_closed = 1'b1;
			// any pattern byte aborts the buffer in progress
			clear_search_state();
		end else begin
			// text past TEXT_MAX is neither shifted in nor searched
			if (txt_cnt < TEXT_MAX) begin
				for (int k = PATTERN_MAX - 1; k > 0; k--)
					win[k] = win[k - 1];
				win[0] = it.data;
				txt_cnt++;
				// only the first full match counts; empty or open pattern never matches
				if (pat_closed && !hit && pat_len != 0 && txt_cnt >= pat_len) begin
					same = 1'b1;
					for (int k = 0; k < pat_len; k++)
						if (win[k] != pat_mem[pat_len - 1 - k])
							same = 1'b0;
					if (same) begin
						hit     = 1'b1;
						hit_off = txt_cnt - pat_len;
					end
				end
			end
			if (it.last) begin
				res.found  = hit;
				res.offset = hit ? offset_t'(hit_off) : '0;
				match_queue.push_back(res);
				clear_search_state();
			end
		end
	endtask

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("mismatch %0d at %0t: %s", mismatch_count, $time, what);
	endtask

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	data_t alpha [4];
	int    alpha_n = 2;

	task automatic queue_byte(input op_t op, input data_t b, input logic last);
		search_item_t it;
		it.op   = op;
		it.data = b;
		it.last = last;
		byte_queue.push_back(it);
	endtask

	// small alphabets make partial and repeated matches common
	function automatic void new_alphabet();
		alpha[0] = data_t'($urandom);
		alpha[1] = alpha[0] ^ data_t'(1 << $urandom_range(0, 7));
		alpha[2] = data_t'($urandom);
		alpha[3] = ~alpha[0];
		alpha_n  = $urandom_range(2, 4);
	endfunction

	function automatic data_t pick_byte();
		if ($urandom_range(0, 9) == 0)
			return data_t'($urandom);
		return alpha[$urandom_range(0, alpha_n - 1)];
	endfunction

	// one text buffer, optionally with the stored part of the pattern planted in it
	task automatic queue_text_buffer(input data_t pat [$], input int blen, input bit plant);
		data_t tx [$];
		int    eff;
		int    pos;
		eff = (pat.size() > PATTERN_MAX) ? PATTERN_MAX : pat.size();
		for (int i = 0; i < blen; i++)
			tx.push_back(pick_byte());
		if (plant && eff > 0 && eff <= blen) begin
			pos = $urandom_range(0, blen - eff);
			for (int j = 0; j < eff; j++)
				tx[pos + j] = pat[j];
		end
		foreach (tx[i])
			queue_byte(OP_TEXT, tx[i], i == blen - 1);
	endtask

	// ------------------------------------------------------------------
	// driver: bursts of random length with random gaps; quiet stretches
	// alternate with stressed ones so gaps land on every phase
	// ------------------------------------------------------------------
	search_item_t on_wire;
	int           gap_left;
	int           burst_left;
	int unsigned  tx_cycles;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid     <= 1'b0;
			item_ch.operation <= OP_PATTERN;
			item_ch.data_byte <= '0;
			item_ch.is_last   <= 1'b0;
			gap_left   = 0;
			burst_left = 0;
			tx_cycles  = 0;
		end else begin
			tx_cycles++;
			// transaction taken at this edge: feed the predictor
			if (item_ch.valid && item_ch.ready) begin
				predict_search(on_wire);
				items_taken++;
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					item_ch.valid <= 1'b0;
				end else if (byte_queue.size() > 0) begin
					on_wire = byte_queue.pop_front();
					item_ch.valid     <= 1'b1;
					item_ch.operation <= on_wire.op;
					item_ch.data_byte <= on_wire.data;
					item_ch.is_last   <= on_wire.last;
					if (burst_left > 0)
						burst_left--;
					else begin
						burst_left = $urandom_range(0, 23);
						gap_left   = tx_cycles[9] ? $urandom_range(1, 8) : 0;
					end
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: checks each result against the oldest prediction, and
	// stalls ready on its own pattern, with calm stretches in between
	// ------------------------------------------------------------------
	match_result_t want;
	int            stall_left;
	int unsigned   rx_cycles;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_left = 0;
			rx_cycles  = 0;
		end else begin
			rx_cycles++;
			if (result_ch.valid && result_ch.ready) begin
				if (match_queue.size() == 0) begin
					report_mismatch($sformatf("result found=%0b offset=%0d with none expected",
						result_ch.found, result_ch.match_offset));
				end else begin
					want = match_queue.pop_front();
					results_seen++;
					if (want.found)
						hits_seen++;
					if (result_ch.found !== want.found)
						report_mismatch($sformatf("found %0b, expected %0b",
							result_ch.found, want.found));
					if (result_ch.match_offset !== want.offset)
						report_mismatch($sformatf("match_offset %0d, expected %0d",
							result_ch.match_offset, want.offset));
				end
			end
			// calm stretch: always ready
			if (rx_cycles[8:7] == 2'b00) begin
				result_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				if ($urandom_range(0, 2) == 0)
					stall_left = $urandom_range(1, 12);
			end
		end
	end

	// watchdog: a long stretch with no transaction on either side means a hang
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus plan, reset and end of run
	// ------------------------------------------------------------------
	initial begin
		int    base;
		int    kind;
		int    sel;
		int    plen;
		data_t pat [$];

		arst_n = 1'b0;

		// directed: no pattern loaded yet, so nothing can match
		queue_byte(OP_TEXT, 8'h5A, 1'b1);
		// zero pattern against the zeroed window: text shorter than pattern
		queue_byte(OP_PATTERN, 8'h00, 1'b0);
		queue_byte(OP_PATTERN, 8'h00, 1'b0);
		queue_byte(OP_PATTERN, 8'h00, 1'b1);
		queue_byte(OP_TEXT, 8'h00, 1'b0);
		queue_byte(OP_TEXT, 8'h00, 1'b1);
		// same pattern, long enough text: match at offset 1
		queue_byte(OP_TEXT, 8'h01, 1'b0);
		queue_byte(OP_TEXT, 8'h00, 1'b0);
		queue_byte(OP_TEXT, 8'h00, 1'b0);
		queue_byte(OP_TEXT, 8'h00, 1'b1);
		// single-byte pattern replaces the closed one; first of two matches wins
		queue_byte(OP_PATTERN, 8'hFF, 1'b1);
		queue_byte(OP_TEXT, 8'h00, 1'b0);
		queue_byte(OP_TEXT, 8'hFF, 1'b0);
		queue_byte(OP_TEXT, 8'hFF, 1'b1);
		// pattern left open: the buffer reports not found
		queue_byte(OP_PATTERN, 8'hAB, 1'b0);
		queue_byte(OP_TEXT, 8'hAB, 1'b1);
		// close it, match mid-buffer, then a pattern byte aborts the buffer
		queue_byte(OP_PATTERN, 8'hCD, 1'b1);
		queue_byte(OP_TEXT, 8'hAB, 1'b0);
		queue_byte(OP_TEXT, 8'hCD, 1'b0);
		queue_byte(OP_PATTERN, 8'h12, 1'b1);
		queue_byte(OP_TEXT, 8'h34, 1'b0);
		queue_byte(OP_TEXT, 8'h12, 1'b1);

		// random: mostly pattern load followed by a few buffers, some noise
		base = byte_queue.size();
		while (byte_queue.size() - base < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 99);
			new_alphabet();
			pat = {};
			if (kind < 78) begin
				sel  = $urandom_range(0, 99);
				plen = (sel < 80) ? $urandom_range(1, 6) :
					(sel < 95) ? $urandom_range(7, PATTERN_MAX) :
					$urandom_range(PATTERN_MAX + 1, PATTERN_MAX + 6);
				for (int i = 0; i < plen; i++)
					pat.push_back(pick_byte());
				foreach (pat[i])
					queue_byte(OP_PATTERN, pat[i], i == plen - 1);
				repeat ($urandom_range(1, 4))
					queue_text_buffer(pat, $urandom_range(1, 24) + ((plen > 24) ? plen : 0),
						$urandom_range(0, 2) != 0);
			end else if (kind < 90) begin
				// noise: any operation, any byte, is_last at random
				repeat ($urandom_range(1, 10))
					queue_byte(op_t'($urandom_range(0, 1)), data_t'($urandom),
						$urandom_range(0, 3) == 0);
			end else begin
				// open pattern followed by a buffer that contains it
				plen = $urandom_range(1, 4);
				for (int i = 0; i < plen; i++)
					pat.push_back(pick_byte());
				foreach (pat[i])
					queue_byte(OP_PATTERN, pat[i], 1'b0);
				queue_text_buffer(pat, $urandom_range(1, 12), 1'b1);
			end
		end

		// oversized pattern: the last two bytes are dropped
		for (int i = 0; i < PATTERN_MAX + 2; i++)
			queue_byte(OP_PATTERN, data_t'(i + 1), i == PATTERN_MAX + 1);
		// the stored part of it, found after a short lead-in
		repeat (3)
			queue_byte(OP_TEXT, 8'h00, 1'b0);
		for (int i = 0; i < PATTERN_MAX; i++)
			queue_byte(OP_TEXT, data_t'(i + 1), i == PATTERN_MAX - 1);

		items_total = byte_queue.size();

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// all stimulus taken, then every predicted result back
		while (items_taken != items_total)
			@(posedge clk);
		while (match_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d input transactions and %0d text buffers, %0d with a match",
			items_taken, results_seen, hits_seen);
		$display("patterns from 1 byte to beyond %0d bytes, with stalls on both sides",
			PATTERN_MAX);
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
